// File: design/tfna_pkg.sv
// ----------------------------------------------------------------------------
// tfna_pkg
// Shared widths, status codes and a pipeline word type for the face unit.
// ----------------------------------------------------------------------------
package tfna_pkg;

    localparam int NODE_DEPTH = 1024;
    localparam int IDX_W      = 10;
    localparam int ADDR_W     = $clog2(NODE_DEPTH);
    localparam int COORD_W    = 24;
    localparam int EDGE_W     = 25;
    localparam int CROSS_W    = 52;
    localparam int MAG_W      = 51;
    localparam int SUMSQ_W    = 102;
    localparam int AREA_W     = 32;
    localparam int NORM_W     = 18;
    localparam int QBITS      = 17;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOT_TRI = 2'd1;
    localparam logic [1:0] ST_DEGEN   = 2'd2;

    localparam logic [NORM_W-1:0] NORM_MAX = NORM_W'(65536);

    typedef struct packed {
        logic                     is_tri;
        logic signed [CROSS_W-1:0] nx;
        logic signed [CROSS_W-1:0] ny;
        logic signed [CROSS_W-1:0] nz;
    } t_cross;

endpackage

// File: design/triangle_face_normal_area.sv
// ----------------------------------------------------------------------------
// triangle_face_normal_area
// Node table, cross product, square root and unit normal pipeline.
// ----------------------------------------------------------------------------
// Pipeline from the accepting edge to o_valid for a face word: table read on
// that edge, then edges, products, cross, partial squares, component squares,
// sum, root, divide plus rounding, output.
// Throughput: one word per cycle; busy is never high. Load words give no result.
// Reset clears the valid pipeline only; the node table is undefined until
// written. The receiver cannot stall.
module triangle_face_normal_area (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_kind,
    input  logic [9:0]           i_node_index,
    input  logic signed [23:0]   i_coord_x,
    input  logic signed [23:0]   i_coord_y,
    input  logic signed [23:0]   i_coord_z,
    input  logic                 i_is_triangle,
    input  logic [9:0]           i_corner_a,
    input  logic [9:0]           i_corner_b,
    input  logic [9:0]           i_corner_c,
    output logic                 o_valid,
    output logic [31:0]          o_area,
    output logic signed [17:0]   o_unit_x,
    output logic signed [17:0]   o_unit_y,
    output logic signed [17:0]   o_unit_z,
    output logic [1:0]           o_status
);
    localparam int CW = tfna_pkg::COORD_W;
    localparam int EW = tfna_pkg::EDGE_W;
    localparam int XW = tfna_pkg::CROSS_W;
    localparam int PW = 2 * EW;
    localparam int DL = tfna_pkg::QBITS + 1;

    assign busy = 1'b0;

    // three copies of the table, one read port each
    logic [3*CW-1:0] r_mem_a [tfna_pkg::NODE_DEPTH];
    logic [3*CW-1:0] r_mem_b [tfna_pkg::NODE_DEPTH];
    logic [3*CW-1:0] r_mem_c [tfna_pkg::NODE_DEPTH];
    logic [3*CW-1:0] r_pa, r_pb, r_pc;
    logic            r_oa, r_ob, r_oc;
    logic            r_v1, r_f1, r_t1;
    logic            n_wr;

    assign n_wr = start && !i_kind && (32'(i_node_index) < tfna_pkg::NODE_DEPTH);

    always_ff @(posedge i_clk) begin
        if (n_wr) begin
            r_mem_a[i_node_index[tfna_pkg::ADDR_W-1:0]] <= {i_coord_x, i_coord_y, i_coord_z};
            r_mem_b[i_node_index[tfna_pkg::ADDR_W-1:0]] <= {i_coord_x, i_coord_y, i_coord_z};
            r_mem_c[i_node_index[tfna_pkg::ADDR_W-1:0]] <= {i_coord_x, i_coord_y, i_coord_z};
        end
        r_pa <= r_mem_a[i_corner_a[tfna_pkg::ADDR_W-1:0]];
        r_pb <= r_mem_b[i_corner_b[tfna_pkg::ADDR_W-1:0]];
        r_pc <= r_mem_c[i_corner_c[tfna_pkg::ADDR_W-1:0]];
        r_oa <= 32'(i_corner_a) >= tfna_pkg::NODE_DEPTH;
        r_ob <= 32'(i_corner_b) >= tfna_pkg::NODE_DEPTH;
        r_oc <= 32'(i_corner_c) >= tfna_pkg::NODE_DEPTH;
        r_t1 <= i_is_triangle;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= start && i_kind;
        end
    end

    // stage 2: edges
    logic signed [CW-1:0] n_a [3], n_b [3], n_c [3];
    logic signed [EW-1:0] r_e1 [3], r_e2 [3];
    logic                 r_v2, r_t2;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_a[i] = r_oa ? '0 : r_pa[(2-i)*CW +: CW];
            n_b[i] = r_ob ? '0 : r_pb[(2-i)*CW +: CW];
            n_c[i] = r_oc ? '0 : r_pc[(2-i)*CW +: CW];
        end
    end
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_e1[i] <= EW'(n_b[i]) - EW'(n_a[i]);
            r_e2[i] <= EW'(n_c[i]) - EW'(n_b[i]);
        end
        r_t2 <= r_t1;
    end

    // stage 3: six products; stage 4: differences
    logic signed [PW-1:0] r_p [6];
    logic signed [XW-1:0] r_n [3];
    logic                 r_v3, r_t3, r_v4, r_t4;
    always_ff @(posedge i_clk) begin
        r_p[0] <= r_e1[1] * r_e2[2];
        r_p[1] <= r_e1[2] * r_e2[1];
        r_p[2] <= r_e1[2] * r_e2[0];
        r_p[3] <= r_e1[0] * r_e2[2];
        r_p[4] <= r_e1[0] * r_e2[1];
        r_p[5] <= r_e1[1] * r_e2[0];
        r_t3   <= r_t2;
        for (int i = 0; i < 3; i++)
            r_n[i] <= XW'(r_p[2*i]) - XW'(r_p[2*i+1]);
        r_t4   <= r_t3;
    end

    // stage 5: squares in 26x26 partial products; stage 6: one square per
    // component; stage 7: sum of the three
    logic [XW-1:0]  n_m [3];
    logic [2*XW-1:0] r_hh [3], r_hl [3], r_ll [3];
    logic [tfna_pkg::SUMSQ_W-1:0] r_sq [3];
    logic [tfna_pkg::SUMSQ_W-1:0] r_sum;
    tfna_pkg::t_cross r_c5, r_c6, r_c7, n_c4;
    logic r_v5, r_v6, r_v7;
    always_comb begin
        for (int i = 0; i < 3; i++)
            n_m[i] = r_n[i][XW-1] ? XW'(-r_n[i]) : XW'(r_n[i]);
        n_c4 = '{is_tri: r_t4, nx: r_n[0], ny: r_n[1], nz: r_n[2]};
    end
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_hh[i] <= (2*XW)'(n_m[i][XW-1:XW/2] * n_m[i][XW-1:XW/2]);
            r_hl[i] <= (2*XW)'(n_m[i][XW-1:XW/2] * n_m[i][XW/2-1:0]);
            r_ll[i] <= (2*XW)'(n_m[i][XW/2-1:0] * n_m[i][XW/2-1:0]);
            r_sq[i] <= (tfna_pkg::SUMSQ_W'(r_hh[i]) << XW)
                     + (tfna_pkg::SUMSQ_W'(r_hl[i]) << (XW/2 + 1))
                     + tfna_pkg::SUMSQ_W'(r_ll[i]);
        end
        r_sum <= r_sq[0] + r_sq[1] + r_sq[2];
        r_c5  <= n_c4;
        r_c6  <= r_c5;
        r_c7  <= r_c6;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0; r_v3 <= 1'b0; r_v4 <= 1'b0; r_v5 <= 1'b0; r_v6 <= 1'b0; r_v7 <= 1'b0;
        end else begin
            r_v2 <= r_v1; r_v3 <= r_v2; r_v4 <= r_v3; r_v5 <= r_v4; r_v6 <= r_v5; r_v7 <= r_v6;
        end
    end

    // square root
    logic                      s_v, s_z;
    logic [tfna_pkg::MAG_W:0]  s_root;
    tfna_pkg::t_cross          s_c;
    tfna_isqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v7),
        .i_sumsq (r_sum),
        .i_side  (r_c7),
        .o_valid (s_v),
        .o_root  (s_root),
        .o_zero  (s_z),
        .o_side  (s_c)
    );

    // dividers with a matching delay line for sign, area and status
    logic [tfna_pkg::NORM_W-1:0] d_q [3];
    logic [XW-1:0] n_abs [3];
    logic [tfna_pkg::MAG_W:0] n_den;
    always_comb begin
        n_abs[0] = s_c.nx[XW-1] ? XW'(-s_c.nx) : XW'(s_c.nx);
        n_abs[1] = s_c.ny[XW-1] ? XW'(-s_c.ny) : XW'(s_c.ny);
        n_abs[2] = s_c.nz[XW-1] ? XW'(-s_c.nz) : XW'(s_c.nz);
        n_den    = s_z ? (tfna_pkg::MAG_W+1)'(1) : s_root;
    end
    for (genvar i = 0; i < 3; i++) begin : g_div
        tfna_unit_div u_div (
            .i_clk (i_clk),
            .i_num (n_abs[i]),
            .i_den (n_den),
            .o_quo (d_q[i])
        );
    end

    logic        r_dv  [DL+1];
    logic [2:0]  r_dsg [DL+1];
    logic [1:0]  r_dst [DL+1];
    logic [31:0] r_dar [DL+1];
    logic [tfna_pkg::MAG_W-tfna_pkg::QBITS:0] n_ar;
    always_comb begin
        n_ar     = s_root[tfna_pkg::MAG_W:tfna_pkg::QBITS];
        r_dv[0]  = s_v;
        r_dsg[0] = {s_c.nx[XW-1], s_c.ny[XW-1], s_c.nz[XW-1]};
        r_dst[0] = !s_c.is_tri ? tfna_pkg::ST_NOT_TRI :
                   s_z         ? tfna_pkg::ST_DEGEN   : tfna_pkg::ST_OK;
        r_dar[0] = (n_ar > (tfna_pkg::MAG_W-tfna_pkg::QBITS+1)'(32'hFFFF_FFFF))
                 ? 32'hFFFF_FFFF : 32'(n_ar);
    end
    for (genvar k = 0; k < DL; k++) begin : g_dl
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k+1] <= 1'b0;
            end else begin
                r_dv[k+1] <= r_dv[k];
            end
            r_dsg[k+1] <= r_dsg[k];
            r_dst[k+1] <= r_dst[k];
            r_dar[k+1] <= r_dar[k];
        end
    end

    logic [tfna_pkg::NORM_W-1:0] n_o [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            unique case (r_dst[DL])
                tfna_pkg::ST_NOT_TRI: n_o[i] = tfna_pkg::NORM_MAX;
                tfna_pkg::ST_DEGEN:   n_o[i] = '0;
                default:              n_o[i] = r_dsg[DL][2-i] ? -d_q[i] : d_q[i];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_dv[DL];
        end
        o_area   <= (r_dst[DL] == tfna_pkg::ST_OK) ? r_dar[DL] : 32'd0;
        o_unit_x <= n_o[0];
        o_unit_y <= n_o[1];
        o_unit_z <= n_o[2];
        o_status <= r_dst[DL];
    end
endmodule

// File: design/tfna_isqrt.sv
// ----------------------------------------------------------------------------
// tfna_isqrt
// Pipelined integer square root, one result bit per stage, with sideband.
// ----------------------------------------------------------------------------
module tfna_isqrt (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic [tfna_pkg::SUMSQ_W-1:0]    i_sumsq,
    input  tfna_pkg::t_cross                i_side,
    output logic                            o_valid,
    output logic [tfna_pkg::MAG_W:0]        o_root,
    output logic                            o_zero,
    output tfna_pkg::t_cross                o_side
);
    localparam int NB = tfna_pkg::SUMSQ_W / 2; // 51 root bits
    localparam int RW = tfna_pkg::SUMSQ_W / 2 + 2;

    logic                           r_v    [NB+1];
    logic [tfna_pkg::SUMSQ_W-1:0]   r_s    [NB+1];
    logic [RW-1:0]                  r_rem  [NB+1];
    logic [NB-1:0]                  r_q    [NB+1];
    logic                           r_z    [NB+1];
    tfna_pkg::t_cross               r_sd   [NB+1];

    always_comb begin
        r_v[0]   = i_valid;
        r_s[0]   = i_sumsq;
        r_rem[0] = '0;
        r_q[0]   = '0;
        r_z[0]   = (i_sumsq == '0);
        r_sd[0]  = i_side;
    end

    // restoring digit recurrence: bring down two bits, trial subtract 4q+1
    for (genvar k = 0; k < NB; k++) begin : g_st
        logic [RW-1:0] n_rem, n_trial;
        always_comb begin
            n_rem   = {r_rem[k][RW-3:0],
                       r_s[k][tfna_pkg::SUMSQ_W-1-2*k -: 2]};
            n_trial = {r_q[k][RW-3:0], 2'b01};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else begin
                r_v[k+1] <= r_v[k];
            end
            r_s[k+1]  <= r_s[k];
            r_z[k+1]  <= r_z[k];
            r_sd[k+1] <= r_sd[k];
            if (n_rem >= n_trial) begin
                r_rem[k+1] <= n_rem - n_trial;
                r_q[k+1]   <= {r_q[k][NB-2:0], 1'b1};
            end else begin
                r_rem[k+1] <= n_rem;
                r_q[k+1]   <= {r_q[k][NB-2:0], 1'b0};
            end
        end
    end

    assign o_valid = r_v[NB];
    assign o_root  = {1'b0, r_q[NB]};
    assign o_zero  = r_z[NB];
    assign o_side  = r_sd[NB];
endmodule

// File: design/tfna_unit_div.sv
// ----------------------------------------------------------------------------
// tfna_unit_div
// Pipelined restoring divider: round(|c| * 2^16 / mag), one bit per stage.
// ----------------------------------------------------------------------------
module tfna_unit_div (
    input  logic                           i_clk,
    input  logic [tfna_pkg::CROSS_W-1:0]   i_num,
    input  logic [tfna_pkg::MAG_W:0]       i_den,
    output logic [tfna_pkg::NORM_W-1:0]    o_quo
);
    localparam int DW = tfna_pkg::MAG_W + 1;
    localparam int NS = tfna_pkg::QBITS;   // first bit plus 16 fraction bits

    logic [DW:0]                    r_rem [NS+1];
    logic [DW-1:0]                  r_den [NS+1];
    logic [tfna_pkg::QBITS-1:0]     r_q   [NS+1];

    always_comb begin
        r_rem[0] = (DW+1)'(i_num);
        r_den[0] = i_den;
        r_q[0]   = '0;
    end

    for (genvar k = 0; k < NS; k++) begin : g_st
        logic [DW:0] n_r;
        always_comb n_r = (k == 0) ? r_rem[k] : {r_rem[k][DW-1:0], 1'b0};
        always_ff @(posedge i_clk) begin
            r_den[k+1] <= r_den[k];
            if (n_r >= {1'b0, r_den[k]}) begin
                r_rem[k+1] <= n_r - {1'b0, r_den[k]};
                r_q[k+1]   <= {r_q[k][tfna_pkg::QBITS-2:0], 1'b1};
            end else begin
                r_rem[k+1] <= n_r;
                r_q[k+1]   <= {r_q[k][tfna_pkg::QBITS-2:0], 1'b0};
            end
        end
    end

    // round half up: 2r >= mag
    always_ff @(posedge i_clk) begin
        o_quo <= tfna_pkg::NORM_W'(r_q[NS])
               + tfna_pkg::NORM_W'({r_rem[NS], 1'b0} >= {2'b0, r_den[NS]});
    end
endmodule

// File: tb/triangle_face_normal_area_tb.sv
// ----------------------------------------------------------------------------
// triangle_face_normal_area_tb
// Self-checking bench for the face normal and area unit. It loads the node
// table, sends face words in bursts with random gaps, and predicts each
// face result with exact integer math. Every o_valid word is compared
// field by field with the oldest pending prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module triangle_face_normal_area_tb;

    typedef struct packed {
        logic [tfna_pkg::AREA_W-1:0]        area;
        logic signed [tfna_pkg::NORM_W-1:0] nx;
        logic signed [tfna_pkg::NORM_W-1:0] ny;
        logic signed [tfna_pkg::NORM_W-1:0] nz;
        logic [1:0]                         status;
    } t_face_result;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_FACE = 1'b1;
    localparam int   LATENCY   = 76;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                start;
    logic                                busy;
    logic                                i_kind;
    logic [9:0]                          i_node_index;
    logic signed [tfna_pkg::COORD_W-1:0] i_coord_x, i_coord_y, i_coord_z;
    logic                                i_is_triangle;
    logic [9:0]                          i_corner_a, i_corner_b, i_corner_c;
    logic                                o_valid;
    logic [31:0]                         o_area;
    logic signed [17:0]                  o_unit_x, o_unit_y, o_unit_z;
    logic [1:0]                          o_status;

    triangle_face_normal_area dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_kind        (i_kind),
        .i_node_index  (i_node_index),
        .i_coord_x     (i_coord_x),
        .i_coord_y     (i_coord_y),
        .i_coord_z     (i_coord_z),
        .i_is_triangle (i_is_triangle),
        .i_corner_a    (i_corner_a),
        .i_corner_b    (i_corner_b),
        .i_corner_c    (i_corner_c),
        .o_valid       (o_valid),
        .o_area        (o_area),
        .o_unit_x      (o_unit_x),
        .o_unit_y      (o_unit_y),
        .o_unit_z      (o_unit_z),
        .o_status      (o_status)
    );

    // shadow node table
    logic signed [tfna_pkg::COORD_W-1:0] node_x [tfna_pkg::NODE_DEPTH];
    logic signed [tfna_pkg::COORD_W-1:0] node_y [tfna_pkg::NODE_DEPTH];
    logic signed [tfna_pkg::COORD_W-1:0] node_z [tfna_pkg::NODE_DEPTH];
    bit                                  node_written [tfna_pkg::NODE_DEPTH];
    int                                  loaded_nodes [$];

    t_face_result pending_faces [$];
    int errors, n_loads, n_faces, n_degen, n_not_tri, n_sat, burst_left;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic logic [63:0] isqrt(logic [127:0] s);
        logic [63:0]  r;
        logic [63:0]  t;
        logic [127:0] sq;
        r = '0;
        for (int k = 51; k >= 0; k--) begin
            t  = r | (64'd1 << k);
            sq = {64'd0, t} * {64'd0, t};
            if (sq <= s) r = t;
        end
        return r;
    endfunction

    function automatic logic signed [tfna_pkg::NORM_W-1:0] unit_comp(longint c,
                                                                    logic [63:0] mag);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = (c < 0) ? 64'(-c) : 64'(c);
        if (r >= mag) begin
            q = 1;
            r = r - mag;
        end
        for (int i = 0; i < 16; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= mag) begin
                q = q | 1;
                r = r - mag;
            end
        end
        if (r >= mag - r) q = q + 1;
        return (c < 0) ? tfna_pkg::NORM_W'(-q) : tfna_pkg::NORM_W'(q);
    endfunction

    function automatic t_face_result face_normal_area(logic is_tri, int a, int b, int c);
        t_face_result res;
        longint       e1 [3];
        longint       e2 [3];
        longint       n [3];
        logic [127:0] sumsq;
        logic [127:0] m;
        logic [63:0]  mag;
        logic [63:0]  ar;
        if (!is_tri) begin
            res = '{0, tfna_pkg::NORM_MAX, tfna_pkg::NORM_MAX, tfna_pkg::NORM_MAX,
                    tfna_pkg::ST_NOT_TRI};
            return res;
        end
        e1[0] = longint'(node_x[b]) - longint'(node_x[a]);
        e1[1] = longint'(node_y[b]) - longint'(node_y[a]);
        e1[2] = longint'(node_z[b]) - longint'(node_z[a]);
        e2[0] = longint'(node_x[c]) - longint'(node_x[b]);
        e2[1] = longint'(node_y[c]) - longint'(node_y[b]);
        e2[2] = longint'(node_z[c]) - longint'(node_z[b]);
        n[0] = e1[1] * e2[2] - e1[2] * e2[1];
        n[1] = e1[2] * e2[0] - e1[0] * e2[2];
        n[2] = e1[0] * e2[1] - e1[1] * e2[0];
        sumsq = '0;
        for (int i = 0; i < 3; i++) begin
            m     = (n[i] < 0) ? 128'(-n[i]) : 128'(n[i]);
            sumsq = sumsq + m * m;
        end
        if (sumsq == 0) begin
            res = '{0, 0, 0, 0, tfna_pkg::ST_DEGEN};
            return res;
        end
        mag = isqrt(sumsq);
        ar  = mag >> tfna_pkg::QBITS;
        res.area   = (ar > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : ar[31:0];
        res.nx     = unit_comp(n[0], mag);
        res.ny     = unit_comp(n[1], mag);
        res.nz     = unit_comp(n[2], mag);
        res.status = tfna_pkg::ST_OK;
        return res;
    endfunction

    // drive one word, hold until accepted, then update the shadow model
    task automatic send_word(logic kind, int idx, int x, int y, int z,
                             logic is_tri, int a, int b, int c);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        start         <= 1'b1;
        i_kind        <= kind;
        i_node_index  <= idx[9:0];
        i_coord_x     <= x[23:0];
        i_coord_y     <= y[23:0];
        i_coord_z     <= z[23:0];
        i_is_triangle <= is_tri;
        i_corner_a    <= a[9:0];
        i_corner_b    <= b[9:0];
        i_corner_c    <= c[9:0];
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (kind == KIND_LOAD) begin
            node_x[idx] = x[23:0];
            node_y[idx] = y[23:0];
            node_z[idx] = z[23:0];
            if (!node_written[idx]) loaded_nodes.insert(loaded_nodes.size(), idx);
            node_written[idx] = 1'b1;
            n_loads++;
        end else begin
            pending_faces.insert(pending_faces.size(), face_normal_area(is_tri, a, b, c));
            n_faces++;
        end
    endtask

    task automatic load_node(int idx, int x, int y, int z);
        send_word(KIND_LOAD, idx, x, y, z, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic face(logic is_tri, int a, int b, int c);
        send_word(KIND_FACE, $urandom, $urandom, $urandom, $urandom, is_tri, a, b, c);
    endtask

    function automatic int any_node();
        return loaded_nodes[$urandom_range(0, loaded_nodes.size() - 1)];
    endfunction

    function automatic int rand_coord();
        case ($urandom_range(0, 4))
            0:       return $urandom_range(0, 1) ? 8388607 : -8388608;
            1:       return $signed($urandom_range(0, 512)) - 256;
            2:       return ($signed($urandom_range(0, 8)) - 4) * 65536;
            default: return $signed({$urandom} << 8) >>> 8;
        endcase
    endfunction

    task automatic test_directed_loads();
        load_node(0, -8388608, -8388608, -8388608);
        load_node(1023, 8388607, 8388607, 8388607);
        load_node(1, 8388607, -8388608, 8388607);
        load_node(2, -8388608, 8388607, 0);
        load_node(3, 65536, 0, 0);
        load_node(4, 0, 65536, 0);
        load_node(5, 0, 0, 0);
        load_node(6, 131072, 0, 0); // on the line through 5 and 3
    endtask

    task automatic test_faces_basic();
        face(1'b1, 5, 3, 4);     // unit right triangle in xy
        face(1'b1, 5, 4, 3);     // reversed winding
        face(1'b0, 0, 1023, 1);  // not a triangle
        face(1'b1, 0, 1023, 1);  // large extents
        face(1'b1, 1023, 1, 2);
        face(1'b1, 0, 1, 2);
    endtask

    task automatic test_degenerate();
        face(1'b1, 3, 3, 4);     // repeated corner
        face(1'b1, 5, 3, 6);     // collinear corners
        face(1'b1, 0, 0, 0);
    endtask

    task automatic test_load_then_face();
        // rewrite a node and use it on the very next word
        load_node(4, 0, 0, 65536);
        face(1'b1, 5, 3, 4);
        load_node(7, 8388607, 8388607, -8388608);
        face(1'b1, 0, 2, 7);
        face(1'b1, 1, 2, 7);
    endtask

    task automatic test_random(int count);
        int a, b, c;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 9) < 3) begin
                load_node($urandom_range(0, tfna_pkg::NODE_DEPTH - 1), rand_coord(),
                          rand_coord(), rand_coord());
            end else begin
                a = any_node();
                b = any_node();
                c = any_node();
                if ($urandom_range(0, 9) == 0) c = a;
                face($urandom_range(0, 9) != 0, a, b, c);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_face_result exp_res;
        if (i_rst_n && o_valid) begin
            if (pending_faces.size() == 0) begin
                $display("%0t: unexpected word, exp none, got area=%h status=%0d",
                         $time, o_area, o_status);
                errors++;
            end else begin
                exp_res = pending_faces.pop_front();
                if (o_area !== exp_res.area) begin
                    $display("%0t: area exp %h got %h", $time, exp_res.area, o_area);
                    errors++;
                end
                if (o_unit_x !== exp_res.nx) begin
                    $display("%0t: unit_x exp %0d got %0d", $time, exp_res.nx, o_unit_x);
                    errors++;
                end
                if (o_unit_y !== exp_res.ny) begin
                    $display("%0t: unit_y exp %0d got %0d", $time, exp_res.ny, o_unit_y);
                    errors++;
                end
                if (o_unit_z !== exp_res.nz) begin
                    $display("%0t: unit_z exp %0d got %0d", $time, exp_res.nz, o_unit_z);
                    errors++;
                end
                if (o_status !== exp_res.status) begin
                    $display("%0t: status exp %0d got %0d", $time, exp_res.status, o_status);
                    errors++;
                end
                if (exp_res.status == tfna_pkg::ST_DEGEN) n_degen++;
                if (exp_res.status == tfna_pkg::ST_NOT_TRI) n_not_tri++;
                if (exp_res.area == 32'hFFFF_FFFF) n_sat++;
            end
        end
    end

    initial begin
        int wait_cycles;
        errors = 0;
        burst_left = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_kind = KIND_LOAD;
        i_node_index = '0;
        i_coord_x = '0;
        i_coord_y = '0;
        i_coord_z = '0;
        i_is_triangle = 1'b0;
        i_corner_a = '0;
        i_corner_b = '0;
        i_corner_c = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_loads();
        test_faces_basic();
        test_degenerate();
        test_load_then_face();
        test_random(700);
        start <= 1'b0;

        wait_cycles = 0;
        while (pending_faces.size() != 0 && wait_cycles < 10 * LATENCY) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (2 * LATENCY) @(posedge i_clk);
        if (pending_faces.size() != 0) begin
            $display("%0t: %0d face words never came out", $time, pending_faces.size());
            errors++;
        end

        $display("Sent %0d node loads and %0d faces (%0d not triangles, %0d degenerate,",
                 n_loads, n_faces, n_not_tri, n_degen);
        $display("%0d saturated areas), %0d mismatches.", n_sat, errors);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: triangle_face_normal_area.f
design/tfna_pkg.sv
design/tfna_isqrt.sv
design/tfna_unit_div.sv
design/triangle_face_normal_area.sv
tb/triangle_face_normal_area_tb.sv
